/* sv/rit_pkg.sv */
`timescale 1ns / 1ps
// rit_pkg: shared types and codes of the refcounted intern table unit
// no dependencies; imported by rit_count_alu and refcounted_intern_table_unit

package rit_pkg;

    typedef enum logic [1:0] {
        CMD_INTERN  = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_TAG = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_RESP
    } state_t;

    typedef enum logic {
        ALU_INC_SAT,
        ALU_DEC_FLOOR
    } alu_op_t;

    localparam int KEY_BITS       = 64;
    localparam int TAG_BITS       = 4;
    localparam int COUNT_OUT_BITS = 16;

endpackage

/* sv/rit_ram.sv */
`timescale 1ns / 1ps
// rit_ram: generic single write port, single read port ram with registered read
// no dependencies; used for the key store and the use count store

module rit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/rit_count_alu.sv */
`timescale 1ns / 1ps
// rit_count_alu: shared use count unit, saturating increment or floored decrement
// depends on rit_pkg

module rit_count_alu import rit_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  alu_op_t               op,
    input  logic [COUNT_BITS-1:0] operand,
    output logic [COUNT_BITS-1:0] result
);

    always_comb
    begin
        case (op)
            ALU_INC_SAT:
            begin
                result = (&operand) ? operand : operand + 1'b1;
            end
            ALU_DEC_FLOOR:
            begin
                result = (operand == '0) ? operand : operand - 1'b1;
            end
            default:
            begin
                result = operand;
            end
        endcase
    end

endmodule

/* sv/refcounted_intern_table_unit.sv */
`timescale 1ns / 1ps
// refcounted_intern_table_unit: top level, sequencer over key and count rams
// depends on rit_pkg, rit_ram, rit_count_alu
//
// usage
//   slave channel s_*: one command per transaction, s_tuser = cmd,
//   s_tdata = key and tag. master channel m_*: one result per command,
//   m_tuser = status, m_tdata = tag_out, key_out, count_out.
//   an intern command scans the filled entries one per cycle through the
//   key ram read port and compares each against the key; a hit bumps the
//   count through the shared count unit, a miss appends the key, or gives
//   status full if the table is full. intern reads from one entry (empty
//   table) up to ENTRIES entries, until a hit or the last filled entry;
//   read, release and query pass one execute state. one command is in
//   flight at a time and s_tready is low while it is worked on, so no new
//   command is taken until the result is passed to the output register.
//   results sit in an output register; the next command is accepted while
//   a result waits, and a stalled receiver holds the following result in
//   the response stage until the output register frees.
//   reset empties the table at once (fill level zero); no clearing pass.

module refcounted_intern_table_unit import rit_pkg::*; #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // key [63:0], tag [67:64], zero [71:68]
    input  logic [1:0]  s_tuser,   // cmd [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // tag_out [3:0], key_out [67:4], count_out [83:68], zero
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FW = $clog2(ENTRIES + 1);

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [TAG_BITS-1:0]   tag_reg, tag_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [FW-1:0]         fill_reg, fill_next;

    status_t               res_status_reg, res_status_next;
    logic [TAG_BITS-1:0]   res_tag_reg, res_tag_next;
    logic [KEY_BITS-1:0]   res_key_reg, res_key_next;
    logic [COUNT_BITS-1:0] res_count_reg, res_count_next;

    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg;
    logic [TAG_BITS-1:0]   out_tag_reg;
    logic [KEY_BITS-1:0]   out_key_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic                  load_out;
    logic [31:0]           out_count_wide;

    logic                  key_we;
    logic [IW-1:0]         key_waddr;
    logic [KEY_BITS-1:0]   key_wdata;
    logic [KEY_BITS-1:0]   key_rdata;
    logic                  cnt_we;
    logic [IW-1:0]         cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [COUNT_BITS-1:0] cnt_rdata;
    logic [IW-1:0]         raddr;

    alu_op_t               alu_op;
    logic [COUNT_BITS-1:0] alu_res;

    logic                  hit;
    logic                  last;
    logic                  full;
    logic                  tag_ok;

    rit_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    rit_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (raddr),
        .rdata (cnt_rdata)
    );

    rit_count_alu #(
        .COUNT_BITS (COUNT_BITS)
    ) u_alu (
        .op      (alu_op),
        .operand (cnt_rdata),
        .result  (alu_res)
    );

    assign s_tready = (state_reg == S_IDLE);

    assign hit    = (fill_reg != '0) && (key_rdata == key_reg);
    assign last   = (32'(idx_reg) + 32'd1) >= 32'(fill_reg);
    assign full   = (32'(fill_reg) == ENTRIES);
    assign tag_ok = (32'(tag_reg) < 32'(fill_reg)) && (32'(tag_reg) < ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        tag_reg        <= tag_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_key_reg    <= res_key_next;
        res_count_reg  <= res_count_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_tag_reg    <= res_tag_reg;
            out_key_reg    <= res_key_reg;
            out_count_reg  <= res_count_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        tag_next        = tag_reg;
        idx_next        = idx_reg;
        fill_next       = fill_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_key_next    = res_key_reg;
        res_count_next  = res_count_reg;
        key_we          = 1'b0;
        key_waddr       = IW'(fill_reg);
        key_wdata       = key_reg;
        cnt_we          = 1'b0;
        cnt_waddr       = idx_reg;
        cnt_wdata       = alu_res;
        raddr           = '0;
        alu_op          = ALU_INC_SAT;
        load_out        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next = cmd_t'(s_tuser);
                    key_next = s_tdata[63:0];
                    tag_next = s_tdata[67:64];
                    idx_next = '0;
                    if (cmd_t'(s_tuser) == CMD_INTERN)
                    begin
                        raddr      = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        raddr      = IW'(s_tdata[67:64]);
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    alu_op          = ALU_INC_SAT;
                    cnt_we          = 1'b1;
                    cnt_waddr       = idx_reg;
                    cnt_wdata       = alu_res;
                    res_status_next = ST_OK;
                    res_tag_next    = TAG_BITS'(idx_reg);
                    res_key_next    = key_reg;
                    res_count_next  = alu_res;
                    state_next      = S_RESP;
                end
                else if (last)
                begin
                    if (full)
                    begin
                        res_status_next = ST_FULL;
                        res_tag_next    = '0;
                        res_key_next    = '0;
                        res_count_next  = '0;
                    end
                    else
                    begin
                        key_we          = 1'b1;
                        key_waddr       = IW'(fill_reg);
                        cnt_we          = 1'b1;
                        cnt_waddr       = IW'(fill_reg);
                        cnt_wdata       = COUNT_BITS'(1);
                        fill_next       = fill_reg + 1'b1;
                        res_status_next = ST_OK;
                        res_tag_next    = TAG_BITS'(fill_reg);
                        res_key_next    = key_reg;
                        res_count_next  = COUNT_BITS'(1);
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    raddr    = idx_reg + 1'b1;
                end
            end
            S_EXEC:
            begin
                res_tag_next = tag_reg;
                res_key_next = '0;
                if (!tag_ok)
                begin
                    res_status_next = ST_BAD_TAG;
                    res_count_next  = '0;
                end
                else
                begin
                    res_status_next = ST_OK;
                    case (cmd_reg)
                        CMD_READ:
                        begin
                            res_key_next   = key_rdata;
                            res_count_next = cnt_rdata;
                        end
                        CMD_RELEASE:
                        begin
                            alu_op         = ALU_DEC_FLOOR;
                            cnt_we         = 1'b1;
                            cnt_waddr      = IW'(tag_reg);
                            cnt_wdata      = alu_res;
                            res_count_next = alu_res;
                        end
                        default:
                        begin
                            res_count_next = cnt_rdata;
                        end
                    endcase
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_count_wide = 32'(out_count_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_count_wide[COUNT_OUT_BITS-1:0], out_key_reg, out_tag_reg};

`ifndef SYNTHESIS
    // fill level only ever grows by one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (32'(fill_reg) == 32'($past(fill_reg)) + 32'd1))
        else $error("fill level moved by other than one");

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= ENTRIES)
        else $error("fill level beyond table size");

    // table full is only reported once every entry is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_FULL)) |-> full)
        else $error("table full reported with free entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command accepted while busy");
`endif

endmodule
